// ----- sv/mmfh_pkg.sv -----
// Package for the multi-lane multiply-fold hash: constants, types, helpers.
// No dependencies.
`timescale 1ns / 1ps
package mmfh_pkg;
	localparam int BLOCK_BYTES = 64;
	localparam logic [63:0] K0 = 64'hc3a5c85c97cb3127;
	localparam logic [63:0] K1 = 64'hb492b66fbe98f273;
	localparam logic [63:0] K2 = 64'h9ae16a3b2f90404f;
	localparam logic [63:0] K3 = 64'hc949d7c7509e6557;
	localparam logic [63:0] K4 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] K5 = 64'hc4ceb9fe1a85ec53;
	localparam int ROT = 29;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [2:0] LEN_WORD = 3'd7;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_LANE  = 8'b0000_0010,
		ST_PADW  = 8'b0000_0100,
		ST_MIXL  = 8'b0000_1000,
		ST_COMB  = 8'b0001_0000,
		ST_FMIX  = 8'b0010_0000,
		ST_OUT   = 8'b0100_0000,
		ST_MULW  = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		AC_LANE = 2'd0,
		AC_MIX  = 2'd1,
		AC_COMB = 2'd2,
		AC_FIN  = 2'd3
	} acc_t;

	function automatic logic [63:0] rotl29(input logic [63:0] h);
		rotl29 = {h[63-ROT:0], h[63:64-ROT]};
	endfunction
endpackage

// ----- sv/multilane_multiply_fold_hash64.sv -----
// Top level of the multi-lane multiply-fold hash.
// Uses mmfh_pkg. Checker is bound from mmfh_checker.sv.
`timescale 1ns / 1ps
// Streaming keyed 64-bit hash. Beats carry 0..8 little-endian bytes plus a
// last flag. Bytes are packed into an 8-entry 64-bit word store; a full
// 64-byte block runs four lane rounds. All multiplies go through one shared
// 32x32 multiplier, four partial products per 64x64 product (each product:
// operand load, four partial products, fold). A beat that neither finishes
// a block nor is last leaves in_stall low; a beat that finishes a block
// keeps in_stall high for the 4 lane rounds. A last beat adds padding (the
// words from the 0x80 word to the length word, one at a time), the lane
// rounds of each padded block, four output rotate-multiplies, two combine
// rounds, a final mix and an output state. The hash is held in an output
// register until taken; the next message streams in meanwhile, and only a
// second hash waits in the sequencer (input stalled) while one is still held.
// A seed write while no message is open reloads the lanes at once.
module multilane_multiply_fold_hash64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value,
	input  logic        seed_we,
	input  logic [63:0] seed_wdata
);
	localparam int NW = mmfh_pkg::BLOCK_BYTES / 8;
	localparam int BW = $clog2(mmfh_pkg::BLOCK_BYTES);
	localparam int WW = $clog2(NW);

	mmfh_pkg::state_t st_q, ret_q;
	mmfh_pkg::acc_t   acc_q;
	logic [63:0] seed_q, lane_q [4];
	logic [63:0] wbuf_q [NW];
	logic [63:0] part_q;     // partially filled word
	logic [BW-1:0] fill_q;   // bytes in block
	logic [63:0] len_q;
	logic [63:0] ma_q, mb_q; // multiplier operands
	logic [63:0] lo_q, hi_q; // product accumulators
	logic [2:0]  pp_q;       // partial product step
	logic [1:0]  li_q;       // lane index
	logic        fin_q, padded_q;
	logic [63:0] hacc_q;
	logic        ov_q;
	logic [63:0] hv_q;

	// staging of incoming bytes
	logic [3:0]  cnt;
	logic [2:0]  boff;
	logic [127:0] sh;
	logic [63:0] mask_lo;
	logic [127:0] msk;
	logic [127:0] merged;
	logic [BW:0] nfill;

	always_comb begin
		cnt = (byte_count > 4'd8) ? 4'd8 : byte_count;
		boff = fill_q[2:0];
		mask_lo = (cnt == 4'd8) ? '1 : ((64'd1 << {cnt, 3'b000}) - 64'd1);
		sh = {64'd0, data_word & mask_lo} << {boff, 3'b000};
		msk = {64'd0, mask_lo} << {boff, 3'b000};
		merged = ({64'd0, part_q} & ~msk) | sh;
		nfill = {1'b0, fill_q} + {{(BW-3){1'b0}}, cnt};
	end

	// shared 32x32 multiplier
	logic [31:0] mx, my;
	logic [63:0] mp;
	always_comb begin
		mx = pp_q[0] ? ma_q[63:32] : ma_q[31:0];
		my = pp_q[1] ? mb_q[63:32] : mb_q[31:0];
		mp = mx * my;
	end
	logic [127:0] pp_sh, acc_sum;
	always_comb begin
		// hi x hi lands 64 bits up, cross terms 32
		pp_sh = {64'd0, mp} << {{1'b0, pp_q[0]} + {1'b0, pp_q[1]}, 5'd0};
		acc_sum = {hi_q, lo_q} + pp_sh;
	end
	logic [63:0] fold;
	assign fold = lo_q ^ hi_q;

	logic accept;
	assign accept = in_valid && !in_stall;
	assign in_stall = (st_q != mmfh_pkg::ST_IDLE);
	assign out_valid = ov_q;
	assign hash_value = hv_q;

	// hash leaves the sequencer once the output register is free
	logic emit;
	assign emit = (st_q == mmfh_pkg::ST_OUT) && (!ov_q || !out_stall);

	logic [WW-1:0] wi0, wi1;
	assign wi0 = {li_q, 1'b0};
	assign wi1 = {li_q, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mmfh_pkg::ST_IDLE;
			ret_q <= mmfh_pkg::ST_IDLE;
			acc_q <= mmfh_pkg::AC_LANE;
			seed_q <= '0;
			lane_q[0] <= mmfh_pkg::K2; lane_q[1] <= mmfh_pkg::K3;
			lane_q[2] <= mmfh_pkg::K4; lane_q[3] <= mmfh_pkg::K5;
			fill_q <= '0; len_q <= '0; pp_q <= '0; li_q <= '0;
			fin_q <= 1'b0; padded_q <= 1'b0;
			ma_q <= '0; mb_q <= '0; lo_q <= '0; hi_q <= '0; hacc_q <= '0;
		end else begin
			if (seed_we) begin
				seed_q <= seed_wdata;
				if (fill_q == '0 && len_q == '0) begin
					lane_q[0] <= mmfh_pkg::K2 ^ seed_wdata;
					lane_q[1] <= mmfh_pkg::K3 ^ seed_wdata;
					lane_q[2] <= mmfh_pkg::K4 ^ seed_wdata;
					lane_q[3] <= mmfh_pkg::K5 ^ seed_wdata;
				end
			end
			unique case (st_q)
				mmfh_pkg::ST_IDLE: begin
					if (accept) begin
						len_q <= len_q + {60'd0, cnt};
						fin_q <= last_item;
						padded_q <= 1'b0;
						fill_q <= nfill[BW-1:0];
						li_q <= '0;
						if (nfill[BW]) st_q <= mmfh_pkg::ST_LANE;
						else if (last_item) st_q <= mmfh_pkg::ST_PADW;
					end
				end
				mmfh_pkg::ST_LANE: begin
					// load operands for lane round li_q
					ma_q <= lane_q[li_q] ^ wbuf_q[wi0] ^ mmfh_pkg::K0;
					mb_q <= wbuf_q[wi1] ^ mmfh_pkg::K1;
					acc_q <= mmfh_pkg::AC_LANE;
					pp_q <= '0; lo_q <= '0; hi_q <= '0;
					st_q <= mmfh_pkg::ST_MULW;
				end
				mmfh_pkg::ST_MULW: begin
					if (pp_q[2]) begin
						pp_q <= '0;
						unique case (acc_q)
							mmfh_pkg::AC_LANE: begin
								lane_q[li_q] <= fold;
								li_q <= li_q + 2'd1;
								if (li_q != 2'd3) st_q <= mmfh_pkg::ST_LANE;
								else if (fin_q) st_q <= mmfh_pkg::ST_PADW;
								else if (ret_q == mmfh_pkg::ST_MIXL) begin
									// length block done, go to output mix
									st_q <= mmfh_pkg::ST_MIXL;
									ret_q <= mmfh_pkg::ST_IDLE;
								end else st_q <= mmfh_pkg::ST_IDLE;
							end
							mmfh_pkg::AC_MIX: begin
								lane_q[li_q] <= lo_q;
								li_q <= li_q + 2'd1;
								if (li_q != 2'd3) st_q <= mmfh_pkg::ST_MIXL;
								else st_q <= mmfh_pkg::ST_COMB;
							end
							mmfh_pkg::AC_COMB: begin
								hacc_q <= fold;
								li_q <= li_q + 2'd1;
								if (li_q == 2'd0) st_q <= mmfh_pkg::ST_COMB;
								else st_q <= mmfh_pkg::ST_FMIX;
							end
							mmfh_pkg::AC_FIN: begin
								hacc_q <= lo_q;
								st_q <= mmfh_pkg::ST_OUT;
							end
							default: st_q <= mmfh_pkg::ST_IDLE;
						endcase
					end else begin
						{hi_q, lo_q} <= acc_sum;
						pp_q <= pp_q + 3'd1;
					end
				end
				mmfh_pkg::ST_PADW: begin
					// padding: 0x80 byte once, zero fill, length in last word;
					// 0x80 in the length word closes this block and opens another
					if (!padded_q) begin
						padded_q <= 1'b1;
						fill_q <= {fill_q[BW-1:3] + 1'b1, 3'b000};
						if (fill_q[BW-1:3] == mmfh_pkg::LEN_WORD) begin
							li_q <= '0; st_q <= mmfh_pkg::ST_LANE;
						end
					end else if (fill_q[BW-1:3] == mmfh_pkg::LEN_WORD) begin
						fill_q <= '0; li_q <= '0;
						fin_q <= 1'b0;
						ret_q <= mmfh_pkg::ST_MIXL;
						st_q <= mmfh_pkg::ST_LANE;
					end else
						fill_q <= {fill_q[BW-1:3] + 1'b1, 3'b000};
				end
				mmfh_pkg::ST_MIXL: begin
					ma_q <= mmfh_pkg::rotl29(lane_q[li_q]);
					mb_q <= mmfh_pkg::K1;
					acc_q <= mmfh_pkg::AC_MIX;
					pp_q <= '0; lo_q <= '0; hi_q <= '0;
					st_q <= mmfh_pkg::ST_MULW;
				end
				mmfh_pkg::ST_COMB: begin
					ma_q <= (li_q == 2'd0 ? 64'd0 : hacc_q) ^ lane_q[{li_q[0], 1'b0}]
						^ mmfh_pkg::K0;
					mb_q <= lane_q[{li_q[0], 1'b1}] ^ mmfh_pkg::K1;
					acc_q <= mmfh_pkg::AC_COMB;
					pp_q <= '0; lo_q <= '0; hi_q <= '0;
					st_q <= mmfh_pkg::ST_MULW;
				end
				mmfh_pkg::ST_FMIX: begin
					ma_q <= mmfh_pkg::rotl29(hacc_q);
					mb_q <= mmfh_pkg::K1;
					acc_q <= mmfh_pkg::AC_FIN;
					pp_q <= '0; lo_q <= '0; hi_q <= '0;
					st_q <= mmfh_pkg::ST_MULW;
				end
				mmfh_pkg::ST_OUT: begin
					// waits here while the previous hash is still held
					if (emit) begin
						lane_q[0] <= mmfh_pkg::K2 ^ seed_q;
						lane_q[1] <= mmfh_pkg::K3 ^ seed_q;
						lane_q[2] <= mmfh_pkg::K4 ^ seed_q;
						lane_q[3] <= mmfh_pkg::K5 ^ seed_q;
						fill_q <= '0; len_q <= '0; ret_q <= mmfh_pkg::ST_IDLE;
						st_q <= mmfh_pkg::ST_IDLE;
					end
				end
				default: st_q <= mmfh_pkg::ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			hv_q <= '0;
		end else if (emit) begin
			ov_q <= 1'b1;
			hv_q <= hacc_q;
		end else if (!out_stall)
			ov_q <= 1'b0;
	end

	// word store and partial word
	always_ff @(posedge clk) begin
		if (st_q == mmfh_pkg::ST_IDLE && accept) begin
			part_q <= nfill[BW:3] != {1'b0, fill_q[BW-1:3]} ? merged[127:64] : merged[63:0];
			if (nfill[BW:3] != {1'b0, fill_q[BW-1:3]})
				wbuf_q[fill_q[BW-1:3]] <= merged[63:0];
		end else if (st_q == mmfh_pkg::ST_PADW) begin
			if (!padded_q) begin
				wbuf_q[fill_q[BW-1:3]] <= (part_q & ((64'd1 << {fill_q[2:0], 3'b000}) - 64'd1))
					| ({56'd0, mmfh_pkg::PAD_BYTE} << {fill_q[2:0], 3'b000});
			end else if (fill_q[BW-1:3] == mmfh_pkg::LEN_WORD)
				wbuf_q[fill_q[BW-1:3]] <= len_q;
			else
				wbuf_q[fill_q[BW-1:3]] <= '0;
			part_q <= '0;
		end
	end
endmodule

// ----- sv/mmfh_checker.sv -----
// Port-level checker for multilane_multiply_fold_hash64, bound to the top.
// Uses no package.
`timescale 1ns / 1ps
module mmfh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_item,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] hash_value
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hash_value))
		else $error("result beat dropped while stalled");
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised while sequencer idle");
	a_nolast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last_item && !out_valid |=> !out_valid)
		else $error("result without last beat");
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_item |=> in_stall)
		else $error("not busy after last beat");
endmodule

bind multilane_multiply_fold_hash64 mmfh_checker u_chk (.*);

// ----- dv/multilane_multiply_fold_hash64_tb.sv -----
// Self-checking testbench for multilane_multiply_fold_hash64.
// Depends on mmfh_pkg (hash constants) and the DUT; stand-alone otherwise.
`timescale 1ns / 1ps
module multilane_multiply_fold_hash64_tb;

	// Predictor and expected-hash queue. note_beat takes each accepted beat,
	// check_hash compares each result beat in order.
	class hash_scoreboard;
		logic [63:0] pending[$];
		logic [63:0] seed;
		logic [63:0] lane[4];
		logic [7:0]  blk[64];
		int          fill;
		logic [63:0] msg_len;
		int mismatches;
		int reported;

		function new();
			seed = '0;
			fill = 0;
			msg_len = '0;
			mismatches = 0;
			reported = 0;
			reload_lanes();
		endfunction

		function logic [63:0] fold_mul(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			return p[127:64] ^ p[63:0];
		endfunction

		function logic [63:0] lane_step(logic [63:0] h, logic [63:0] w0,
			logic [63:0] w1);
			return fold_mul(h ^ w0 ^ mmfh_pkg::K0, w1 ^ mmfh_pkg::K1);
		endfunction

		function logic [63:0] rot_mix(logic [63:0] h);
			return {h[34:0], h[63:35]} * mmfh_pkg::K1;
		endfunction

		function void reload_lanes();
			lane[0] = mmfh_pkg::K2 ^ seed;
			lane[1] = mmfh_pkg::K3 ^ seed;
			lane[2] = mmfh_pkg::K4 ^ seed;
			lane[3] = mmfh_pkg::K5 ^ seed;
		endfunction

		function void set_seed(logic [63:0] s);
			seed = s;
			if (fill == 0 && msg_len == 0)
				reload_lanes();
		endfunction

		function void take_byte(logic [7:0] b);
			logic [63:0] w[8];
			blk[fill] = b;
			fill++;
			if (fill == 64) begin
				for (int i = 0; i < 8; i++)
					for (int j = 0; j < 8; j++)
						w[i][8*j +: 8] = blk[8*i + j];
				for (int l = 0; l < 4; l++)
					lane[l] = lane_step(lane[l], w[2*l], w[2*l+1]);
				fill = 0;
			end
		endfunction

		// Advance by one accepted beat; queue the hash on last.
		function void note_beat(logic [63:0] d, logic [3:0] cnt, logic lst);
			int n;
			int pad;
			logic [63:0] tot;
			logic [63:0] h;
			n = (cnt > 8) ? 8 : cnt;
			for (int i = 0; i < n; i++)
				take_byte(d[8*i +: 8]);
			msg_len += 64'(n);
			if (lst) begin
				tot = msg_len;
				pad = (fill < 56) ? 56 - fill : 120 - fill;
				take_byte(mmfh_pkg::PAD_BYTE);
				for (int i = 1; i < pad; i++)
					take_byte(8'h00);
				for (int i = 0; i < 8; i++)
					take_byte(tot[8*i +: 8]);
				h = lane_step(64'd0, rot_mix(lane[0]), rot_mix(lane[1]));
				h = lane_step(h, rot_mix(lane[2]), rot_mix(lane[3]));
				pending.push_back(rot_mix(h));
				reload_lanes();
				fill = 0;
				msg_len = 0;
			end
		endfunction

		function void check_hash(logic [63:0] got);
			logic [63:0] want;
			if (pending.size() == 0) begin
				mismatches++;
				if (reported < 10) begin
					$display("unexpected hash beat: got %h", got);
					reported++;
				end
			end else begin
				want = pending.pop_front();
				if (want !== got) begin
					mismatches++;
					if (reported < 10) begin
						$display("hash mismatch: expected %h got %h", want, got);
						reported++;
					end
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] data_word = '0;
	logic [3:0]  byte_count = '0;
	logic        last_item = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] hash_value;
	logic        seed_we = 1'b0;
	logic [63:0] seed_wdata = '0;

	multilane_multiply_fold_hash64 dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_word(data_word), .byte_count(byte_count), .last_item(last_item),
		.out_valid(out_valid), .out_stall(out_stall), .hash_value(hash_value),
		.seed_we(seed_we), .seed_wdata(seed_wdata)
	);

	always #5 clk = ~clk;

	hash_scoreboard sb;
	int send_idle_pct = 0;  // sender gap chance per beat
	int recv_idle_pct = 0;  // receiver stall chance per cycle
	bit hold_off = 1'b0;    // long receiver stall for back-pressure
	int hold_cycles = 0;

	// Offer one beat and hold it until accepted. Valid stays high into the
	// next beat; gaps and drain() drop it.
	task automatic send_beat(logic [63:0] d, logic [3:0] cnt, logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_word <= d;
		byte_count <= cnt;
		last_item <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_beat(d, cnt, lst);
	endtask

	// Message of nbytes in random-sized beats, then a last beat of 0..8 more bytes;
	// count 9..15 and zero-byte beats mixed in now and then.
	task automatic send_message(int nbytes);
		int left;
		int c;
		logic [63:0] d;
		left = nbytes;
		while (left > 0) begin
			c = $urandom_range(8, 1);
			if ($urandom_range(9) == 0)
				c = 8;
			if (c > left)
				c = left;
			d = {$urandom, $urandom};
			if (c == 8 && $urandom_range(7) == 0)
				send_beat(d, 4'(9 + $urandom_range(6)), 1'b0);
			else if ($urandom_range(15) == 0) begin
				send_beat(d, 4'd0, 1'b0);
				continue;
			end else
				send_beat(d, 4'(c), 1'b0);
			left -= c;
		end
		send_beat({$urandom, $urandom}, 4'($urandom_range(8)), 1'b1);
	endtask

	// Wait until every hash is back, plus the sequencer's worst-case latency.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_seed(logic [63:0] s);
		seed_we <= 1'b1;
		seed_wdata <= s;
		@(posedge clk);
		seed_we <= 1'b0;
		sb.set_seed(s);
	endtask

	// Receiver: random stalls, or a long hold-off when asked.
	always @(posedge clk) begin
		if (hold_off) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles + 1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		if (out_valid && !out_stall)
			sb.check_hash(hash_value);
	end

	initial begin
		#50ms;
		$display("** multilane_multiply_fold_hash64: FAILED **");
		$finish;
	end

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, all-ones beats, zero-byte beats without last,
		// oversize counts, lengths near the padding boundary (55/56/63/64 plus 0..8).
		send_beat(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1);
		send_beat(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
		send_beat(64'h0, 4'd0, 1'b0);
		send_beat(64'h0123_4567_89ab_cdef, 4'd15, 1'b1);
		send_beat(64'hffff_ffff_ffff_ffff, 4'd1, 1'b1);
		send_message(55);
		send_message(56);
		send_message(63);
		send_message(64);
		drain();
		write_seed(64'hffff_ffff_ffff_ffff);
		send_message(7);
		send_message(120);
		drain();

		// Long receiver hold-off while the sender keeps offering beats.
		write_seed(64'h0);
		hold_off = 1'b1;
		fork
			begin
				for (int m = 0; m < 4; m++)
					send_message($urandom_range(20));
			end
			begin
				while (hold_cycles < 2000)
					@(posedge clk);
				hold_off = 1'b0;
			end
		join
		drain();

		// Random: three idling phases, fresh seed for each.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 69 : 0;
			recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 19 : 0;
			write_seed({$urandom, $urandom});
			for (int m = 0; m < 12; m++)
				send_message(($urandom_range(9) == 0) ? $urandom_range(200, 64)
					: $urandom_range(40));
			// A seed write mid-message only applies at the next message start.
			send_beat({$urandom, $urandom}, 4'd5, 1'b0);
			drain();
			write_seed({$urandom, $urandom});
			send_beat({$urandom, $urandom}, 4'd3, 1'b1);
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("** multilane_multiply_fold_hash64: PASSED **");
		else
			$display("** multilane_multiply_fold_hash64: FAILED **");
		$finish;
	end
endmodule

// ----- files.f -----
sv/mmfh_pkg.sv
sv/multilane_multiply_fold_hash64.sv
sv/mmfh_checker.sv
dv/multilane_multiply_fold_hash64_tb.sv
